/* src/pptt_pkg.sv */
package pptt_pkg;

    localparam int IDX_W      = 10;
    localparam int NODE_COUNT = 1 << IDX_W;
    localparam int WALK_LIMIT = 64;
    localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
    localparam int PAIR_W     = 11;
    localparam int CMD_W      = 3;
    localparam int UPC_W      = 5;

    localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DIRECT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ANCESTOR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_ACCEPT     = 4'd1,
        OP_SWEEP      = 4'd2,
        OP_CLR_INIT   = 4'd3,
        OP_SET        = 4'd4,
        OP_GET        = 4'd5,
        OP_DIRECT     = 4'd6,
        OP_ANC        = 4'd7,
        OP_TRUNC      = 4'd8,
        OP_LIST_FIRST = 4'd9,
        OP_LIST_ADV   = 4'd10,
        OP_LIST_EMIT  = 4'd11,
        OP_EMIT_NONE  = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_DONE      = 3'd2,
        C_NOT_LIMIT = 3'd3,
        C_NOT_SWEPT = 3'd4,
        C_DISPATCH  = 3'd5
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
        logic             may_emit;
    } cw_t;

    typedef struct packed {
        logic accepted;
        logic done;
        logic at_limit;
        logic sweep_done;
        logic stall;
    } status_t;

    localparam logic [UPC_W-1:0] U_RSWEEP    = 5'd0;
    localparam logic [UPC_W-1:0] U_IDLE      = 5'd1;
    localparam logic [UPC_W-1:0] U_SET_RD    = 5'd2;
    localparam logic [UPC_W-1:0] U_SET       = 5'd3;
    localparam logic [UPC_W-1:0] U_GET_RD    = 5'd4;
    localparam logic [UPC_W-1:0] U_GET       = 5'd5;
    localparam logic [UPC_W-1:0] U_DIR_RD    = 5'd6;
    localparam logic [UPC_W-1:0] U_DIR       = 5'd7;
    localparam logic [UPC_W-1:0] U_ANC_RD    = 5'd8;
    localparam logic [UPC_W-1:0] U_ANC       = 5'd9;
    localparam logic [UPC_W-1:0] U_ANC_WAIT  = 5'd10;
    localparam logic [UPC_W-1:0] U_ANC_TRUNC = 5'd11;
    localparam logic [UPC_W-1:0] U_LST_RD    = 5'd12;
    localparam logic [UPC_W-1:0] U_LST_FIRST = 5'd13;
    localparam logic [UPC_W-1:0] U_LST_WAIT  = 5'd14;
    localparam logic [UPC_W-1:0] U_LST_EMIT  = 5'd15;
    localparam logic [UPC_W-1:0] U_LST_ADV   = 5'd16;
    localparam logic [UPC_W-1:0] U_CLR_INIT  = 5'd17;
    localparam logic [UPC_W-1:0] U_CLR_SWEEP = 5'd18;
    localparam logic [UPC_W-1:0] U_NONE      = 5'd19;

    function automatic cw_t ucode(input logic [UPC_W-1:0] addr);
        cw_t w;
        case (addr)
            U_RSWEEP:    w = '{OP_SWEEP,      C_NOT_SWEPT, U_RSWEEP,    1'b0};
            U_IDLE:      w = '{OP_ACCEPT,     C_DISPATCH,  U_IDLE,      1'b0};
            U_SET_RD:    w = '{OP_NONE,       C_NEVER,     U_IDLE,      1'b0};
            U_SET:       w = '{OP_SET,        C_ALWAYS,    U_IDLE,      1'b1};
            U_GET_RD:    w = '{OP_NONE,       C_NEVER,     U_IDLE,      1'b0};
            U_GET:       w = '{OP_GET,        C_ALWAYS,    U_IDLE,      1'b1};
            U_DIR_RD:    w = '{OP_NONE,       C_NEVER,     U_IDLE,      1'b0};
            U_DIR:       w = '{OP_DIRECT,     C_ALWAYS,    U_IDLE,      1'b1};
            U_ANC_RD:    w = '{OP_NONE,       C_NEVER,     U_IDLE,      1'b0};
            U_ANC:       w = '{OP_ANC,        C_DONE,      U_IDLE,      1'b1};
            U_ANC_WAIT:  w = '{OP_NONE,       C_NOT_LIMIT, U_ANC,       1'b0};
            U_ANC_TRUNC: w = '{OP_TRUNC,      C_ALWAYS,    U_IDLE,      1'b1};
            U_LST_RD:    w = '{OP_NONE,       C_NEVER,     U_IDLE,      1'b0};
            U_LST_FIRST: w = '{OP_LIST_FIRST, C_DONE,      U_IDLE,      1'b1};
            U_LST_WAIT:  w = '{OP_NONE,       C_NEVER,     U_IDLE,      1'b0};
            U_LST_EMIT:  w = '{OP_LIST_EMIT,  C_DONE,      U_IDLE,      1'b1};
            U_LST_ADV:   w = '{OP_LIST_ADV,   C_ALWAYS,    U_LST_WAIT,  1'b0};
            U_CLR_INIT:  w = '{OP_CLR_INIT,   C_NEVER,     U_IDLE,      1'b0};
            U_CLR_SWEEP: w = '{OP_SWEEP,      C_NOT_SWEPT, U_CLR_SWEEP, 1'b0};
            U_NONE:      w = '{OP_EMIT_NONE,  C_ALWAYS,    U_IDLE,      1'b1};
            default:     w = '{OP_NONE,       C_ALWAYS,    U_IDLE,      1'b0};
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] entry_of(input logic [CMD_W-1:0] cmd);
        logic [UPC_W-1:0] e;
        case (cmd)
            CMD_SET:      e = U_SET_RD;
            CMD_GET:      e = U_GET_RD;
            CMD_DIRECT:   e = U_DIR_RD;
            CMD_ANCESTOR: e = U_ANC_RD;
            CMD_LIST:     e = U_LST_RD;
            CMD_CLEAR:    e = U_CLR_INIT;
            default:      e = U_NONE;
        endcase
        return e;
    endfunction

endpackage

/* src/pptt_ram.sv */
module pptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/pptt_seq.sv */
module pptt_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [pptt_pkg::CMD_W-1:0]  s_cmd,
    input  pptt_pkg::status_t           st,
    output pptt_pkg::cw_t               cw
);
    import pptt_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take;

    assign cw = ucode(upc_reg);

    always_comb begin
        case (cw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_DONE:      take = st.done;
            C_NOT_LIMIT: take = !st.at_limit;
            C_NOT_SWEPT: take = !st.sweep_done;
            default:     take = 1'b0;
        endcase

        if (st.stall) begin
            upc_next = upc_reg;
        end else if (cw.cond == C_DISPATCH) begin
            upc_next = st.accepted ? entry_of(s_cmd) : upc_reg;
        end else if (take) begin
            upc_next = cw.target;
        end else begin
            upc_next = upc_reg + UPC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_RSWEEP;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* src/pptt_datapath.sv */
module pptt_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pptt_pkg::cw_t               cw,
    output pptt_pkg::status_t           st,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pptt_pkg::IDX_W-1:0]  s_parent_index,
    input  logic [pptt_pkg::IDX_W-1:0]  s_child_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [pptt_pkg::IDX_W-1:0]  m_parent_out,
    output logic [pptt_pkg::PAIR_W-1:0] m_pair_count,
    output logic                        m_truncated,
    output logic                        m_last
);
    import pptt_pkg::*;

    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  par_reg, par_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;

    logic              m_valid_reg;
    logic              m_hit_reg;
    logic [IDX_W-1:0]  m_parent_reg;
    logic [PAIR_W-1:0] m_pair_reg;
    logic              m_trunc_reg;
    logic              m_last_reg;

    logic              we;
    logic [IDX_W:0]    wdata;
    logic [IDX_W:0]    rdata;
    logic              rd_valid;
    logic [IDX_W-1:0]  rd_par;

    logic              emit;
    logic              e_hit;
    logic [IDX_W-1:0]  e_par;
    logic              e_trunc;
    logic              e_last;
    logic              at_limit;
    logic              stall;
    logic              accepted;
    logic              walk_end;

    pptt_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (cur_reg),
        .wdata (wdata),
        .raddr (cur_reg),
        .rdata (rdata)
    );

    assign rd_valid = rdata[IDX_W];
    assign rd_par   = rdata[IDX_W-1:0];
    assign at_limit = (steps_reg == STEP_W'(WALK_LIMIT));
    assign walk_end = !rd_valid || at_limit;
    assign stall    = cw.may_emit && m_valid_reg && !m_ready;
    assign s_ready  = (cw.op == OP_ACCEPT);

    always_comb begin
        cur_next   = cur_reg;
        par_next   = par_reg;
        steps_next = steps_reg;
        pair_next  = pair_reg;
        we         = 1'b0;
        wdata      = '0;
        emit       = 1'b0;
        e_hit      = 1'b0;
        e_par      = '0;
        e_trunc    = 1'b0;
        e_last     = 1'b1;
        accepted   = 1'b0;

        case (cw.op)
            OP_ACCEPT: begin
                if (s_valid) begin
                    accepted   = 1'b1;
                    par_next   = s_parent_index;
                    cur_next   = s_child_index;
                    steps_next = '0;
                end
            end
            OP_SWEEP: begin
                we       = 1'b1;
                cur_next = cur_reg + IDX_W'(1);
            end
            OP_CLR_INIT: begin
                cur_next  = '0;
                pair_next = '0;
            end
            OP_SET: begin
                emit = 1'b1;
                if (!rd_valid) begin
                    we        = 1'b1;
                    wdata     = {1'b1, par_reg};
                    pair_next = pair_reg + PAIR_W'(1);
                    e_hit     = 1'b1;
                    e_par     = par_reg;
                end
            end
            OP_GET: begin
                emit  = 1'b1;
                e_hit = rd_valid;
                e_par = rd_valid ? rd_par : '0;
            end
            OP_DIRECT: begin
                emit  = 1'b1;
                e_hit = rd_valid && (rd_par == par_reg);
                e_par = e_hit ? par_reg : '0;
            end
            OP_ANC: begin
                if (!rd_valid) begin
                    emit = 1'b1;
                end else begin
                    cur_next   = rd_par;
                    steps_next = steps_reg + STEP_W'(1);
                    if (rd_par == par_reg) begin
                        emit  = 1'b1;
                        e_hit = 1'b1;
                        e_par = par_reg;
                    end
                end
            end
            OP_TRUNC: begin
                emit    = 1'b1;
                e_trunc = rd_valid;
            end
            OP_LIST_FIRST: begin
                if (!rd_valid) begin
                    emit = 1'b1;
                end else begin
                    cur_next   = rd_par;
                    steps_next = steps_reg + STEP_W'(1);
                end
            end
            OP_LIST_ADV: begin
                cur_next   = rd_par;
                steps_next = steps_reg + STEP_W'(1);
            end
            OP_LIST_EMIT: begin
                emit    = 1'b1;
                e_hit   = 1'b1;
                e_par   = cur_reg;
                e_last  = walk_end;
                e_trunc = walk_end && rd_valid;
            end
            OP_EMIT_NONE: begin
                emit = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // A stalled step must leave every piece of state untouched.
        if (stall) begin
            cur_next   = cur_reg;
            par_next   = par_reg;
            steps_next = steps_reg;
            pair_next  = pair_reg;
            we         = 1'b0;
            emit       = 1'b0;
        end
    end

    assign st = '{
        accepted:   accepted,
        done:       emit && e_last,
        at_limit:   at_limit,
        sweep_done: (cur_reg == IDX_W'(NODE_COUNT - 1)),
        stall:      stall
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= '0;
            pair_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_reg  <= cur_next;
            pair_reg <= pair_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        par_reg   <= par_next;
        steps_reg <= steps_next;
        if (emit) begin
            m_hit_reg    <= e_hit;
            m_parent_reg <= e_par;
            m_pair_reg   <= pair_next;
            m_trunc_reg  <= e_trunc;
            m_last_reg   <= e_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_parent_out = m_parent_reg;
    assign m_pair_count = m_pair_reg;
    assign m_truncated  = m_trunc_reg;
    assign m_last       = m_last_reg;

endmodule

/* src/parent_pointer_tree_table.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  cmd, parent_index, child_index
// m_        out        m_valid / m_ready  hit, parent_out, pair_count, truncated, last
//
// One transaction at a time, run by a microcode step counter over one table RAM.
// Set, get and direct-parent read, then answer; unused codes answer at once. The
// registered RAM read sets the pace: an ancestor test takes ancestor and wait steps per
// node read, a list wait, emit and advance steps per ancestor. Reset and the clear
// command sweep the 1024-entry RAM one entry per cycle with s_ready low.
// A result step holds while the output register is full and m_ready is low.
module parent_pointer_tree_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pptt_pkg::CMD_W-1:0]  s_cmd,
    input  logic [pptt_pkg::IDX_W-1:0]  s_parent_index,
    input  logic [pptt_pkg::IDX_W-1:0]  s_child_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [pptt_pkg::IDX_W-1:0]  m_parent_out,
    output logic [pptt_pkg::PAIR_W-1:0] m_pair_count,
    output logic                        m_truncated,
    output logic                        m_last
);
    import pptt_pkg::*;

    cw_t     cw;
    status_t st;

    pptt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_cmd   (s_cmd),
        .st      (st),
        .cw      (cw)
    );

    pptt_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cw             (cw),
        .st             (st),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_parent_index (s_parent_index),
        .s_child_index  (s_child_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_parent_out   (m_parent_out),
        .m_pair_count   (m_pair_count),
        .m_truncated    (m_truncated),
        .m_last         (m_last)
    );

endmodule

/* src/pptt_checker.sv */
module pptt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [pptt_pkg::CMD_W-1:0]  s_cmd,
    input logic [pptt_pkg::IDX_W-1:0]  s_parent_index,
    input logic [pptt_pkg::IDX_W-1:0]  s_child_index,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_hit,
    input logic [pptt_pkg::IDX_W-1:0]  m_parent_out,
    input logic [pptt_pkg::PAIR_W-1:0] m_pair_count,
    input logic                        m_truncated,
    input logic                        m_last
);
    import pptt_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_hit, m_parent_out, m_pair_count,
                                                    m_truncated, m_last}))
        else $error("Result changed while stalled.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted while a command is in progress.");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_parent_out == '0)
        else $error("Parent output is nonzero on a miss.");

    a_trunc_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_last)
        else $error("Truncation flagged on a result that is not the final one.");

    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_pair_count != '0)
        else $error("Hit reported while the table holds no pairs.");

endmodule

bind parent_pointer_tree_table pptt_checker u_pptt_checker (.*);
